FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/cjss_pkg.sv
// Shared types and constants of the closest joint solution selector.
package cjss_pkg;

	localparam int MAX_JOINTS      = 6;
	localparam int DEF_JOINT_COUNT = 6;
	localparam int DEF_STEP_BITS   = 24;
	localparam int TIE_JOINT       = 2;

	localparam logic OP_CURRENT   = 1'b0;
	localparam logic OP_CANDIDATE = 1'b1;

	typedef struct packed {
		logic valid;
		logic op;
		logic last;
	} cjss_ctl_t;

endpackage

FILE: sv/cjss_lane.sv
// One joint lane: holds the reference step count and registers the absolute step distance.
module cjss_lane #(
	parameter int STEP_BITS = cjss_pkg::DEF_STEP_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_ref,
	input  logic                 step_en,
	input  logic [STEP_BITS-1:0] joint,
	output logic [STEP_BITS-1:0] joint_s1,
	output logic [STEP_BITS-1:0] dist_s1
);
	import cjss_pkg::*;

	logic [STEP_BITS-1:0] ref_q;
	logic [STEP_BITS:0]   diff;
	logic [STEP_BITS:0]   mag;

	assign diff = {joint[STEP_BITS-1], joint} - {ref_q[STEP_BITS-1], ref_q};
	assign mag  = diff[STEP_BITS] ? (~diff + 1'b1) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
		end else if (load_ref) begin
			ref_q <= joint;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			joint_s1 <= joint;
			dist_s1  <= mag[STEP_BITS-1:0];
		end
	end

endmodule

FILE: sv/cjss_merge.sv
// Merge stage: sums lane distances, keeps the best candidate and holds the result register.
module cjss_merge #(
	parameter int JOINT_COUNT = cjss_pkg::DEF_JOINT_COUNT,
	parameter int STEP_BITS   = cjss_pkg::DEF_STEP_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cjss_pkg::cjss_ctl_t                   ctl_s1,
	input  logic [JOINT_COUNT-1:0][STEP_BITS-1:0] joint_s1,
	input  logic [JOINT_COUNT-1:0][STEP_BITS-1:0] dist_s1,
	output logic                                  adv_s2,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [JOINT_COUNT-1:0][STEP_BITS-1:0] out_joint,
	output logic                                  out_from_cand
);
	import cjss_pkg::*;

	localparam int COST_W = STEP_BITS + $clog2(MAX_JOINTS);

	typedef logic [JOINT_COUNT-1:0][STEP_BITS-1:0] pose_t;

	cjss_ctl_t          ctl_s2;
	logic [COST_W-1:0]  cost_s2;
	pose_t              joint_s2;
	logic [COST_W-1:0]  cost_sum;

	pose_t              ref_pose_q;
	pose_t              kept_pose_q;
	logic [COST_W-1:0]  kept_cost_q;
	logic               have_q;

	pose_t              ref_pose_d;
	pose_t              kept_pose_d;
	logic [COST_W-1:0]  kept_cost_d;
	logic               have_d;
	logic [COST_W-1:0]  kept_cost_nx;
	logic               have_nx;
	logic               take;
	logic               consume;

	logic               out_valid_q;
	pose_t              out_joint_q;
	logic               out_from_q;

	always_comb begin
		cost_sum = '0;
		for (int i = 0; i < JOINT_COUNT; i++) begin
			cost_sum = cost_sum + COST_W'(dist_s1[i]);
		end
	end

	always_comb begin
		ref_pose_d  = ref_pose_q;
		kept_pose_d = kept_pose_q;
		kept_cost_d = kept_cost_q;
		have_d      = have_q;
		take        = 1'b0;
		if (ctl_s2.op == OP_CURRENT) begin
			ref_pose_d  = joint_s2;
			have_d      = 1'b0;
			kept_cost_d = '1;
		end else begin
			take = !have_q || (cost_s2 < kept_cost_q) ||
				((cost_s2 == kept_cost_q) &&
				($signed(joint_s2[TIE_JOINT]) > $signed(kept_pose_q[TIE_JOINT])));
			if (take) begin
				kept_pose_d = joint_s2;
				kept_cost_d = cost_s2;
				have_d      = 1'b1;
			end
		end
		// emitting closes the selection
		if (ctl_s2.last) begin
			have_nx      = 1'b0;
			kept_cost_nx = '1;
		end else begin
			have_nx      = have_d;
			kept_cost_nx = kept_cost_d;
		end
	end

	assign consume = ctl_s2.valid && (!ctl_s2.last || !out_valid_q || out_ready);
	assign adv_s2  = !ctl_s2.valid || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv_s2) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cost_s2  <= cost_sum;
			joint_s2 <= joint_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_pose_q  <= '0;
			kept_pose_q <= '0;
			kept_cost_q <= '1;
			have_q      <= 1'b0;
		end else if (consume) begin
			ref_pose_q  <= ref_pose_d;
			kept_pose_q <= kept_pose_d;
			kept_cost_q <= kept_cost_nx;
			have_q      <= have_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && ctl_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && ctl_s2.last) begin
			out_joint_q <= have_d ? kept_pose_d : ref_pose_d;
			out_from_q  <= have_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_joint     = out_joint_q;
	assign out_from_cand = out_from_q;

endmodule

FILE: sv/closest_joint_solution_select_unit.sv
// Top level of the closest joint solution selector.
//
// channel  | beat                                   | tdata / tuser / tlast
// s_axis   | current position or candidate solution | joints / operation / end of selection
// m_axis   | chosen solution                        | best joints / from_candidate / -
//
// One beat per cycle on s_axis while tready is high; lanes and adder tree fully pipelined.
// An accepted last beat passes the lane, sum and select registers before m_axis_tvalid rises.
// s_axis_tready drops only while a last beat waits behind a result not yet taken.
// Reset clears all valid flags and loads an all-zero reference position.
module closest_joint_solution_select_unit #(
	parameter int JOINT_COUNT = cjss_pkg::DEF_JOINT_COUNT,
	parameter int STEP_BITS   = cjss_pkg::DEF_STEP_BITS,
	localparam int DATA_W     = ((cjss_pkg::MAX_JOINTS * STEP_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // joint0 .. joint5, STEP_BITS each
	input  logic [0:0]        s_axis_tuser,  // operation
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // best_joint0 .. best_joint5, STEP_BITS each
	output logic [0:0]        m_axis_tuser   // from_candidate
);
	import cjss_pkg::*;

	cjss_ctl_t                             ctl_s1;
	logic [JOINT_COUNT-1:0][STEP_BITS-1:0] joint_s1;
	logic [JOINT_COUNT-1:0][STEP_BITS-1:0] dist_s1;
	logic [JOINT_COUNT-1:0][STEP_BITS-1:0] out_joint;
	logic                                  out_from_cand;
	logic                                  adv_s1;
	logic                                  adv_s2;
	logic                                  accept;
	logic                                  load_ref;

	assign adv_s1        = !ctl_s1.valid || adv_s2;
	assign s_axis_tready = adv_s1;
	assign accept        = s_axis_tvalid && adv_s1;
	assign load_ref      = accept && (s_axis_tuser[0] == OP_CURRENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv_s1) begin
			ctl_s1.valid <= accept;
			ctl_s1.op    <= s_axis_tuser[0];
			ctl_s1.last  <= s_axis_tlast;
		end
	end

	for (genvar i = 0; i < JOINT_COUNT; i++) begin : g_lane
		cjss_lane #(
			.STEP_BITS(STEP_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.load_ref(load_ref),
			.step_en (adv_s1),
			.joint   (s_axis_tdata[i*STEP_BITS +: STEP_BITS]),
			.joint_s1(joint_s1[i]),
			.dist_s1 (dist_s1[i])
		);
	end

	cjss_merge #(
		.JOINT_COUNT(JOINT_COUNT),
		.STEP_BITS  (STEP_BITS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.joint_s1     (joint_s1),
		.dist_s1      (dist_s1),
		.adv_s2       (adv_s2),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_joint    (out_joint),
		.out_from_cand(out_from_cand)
	);

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < JOINT_COUNT; i++) begin
			m_axis_tdata[i*STEP_BITS +: STEP_BITS] = out_joint[i];
		end
	end

	assign m_axis_tuser[0] = out_from_cand;

endmodule

FILE: sv/cjss_checker.sv
// Port-level checks of the closest joint solution selector, bound to the top level.
`include "assert_macros.svh"

module cjss_checker #(
	parameter int JOINT_COUNT = cjss_pkg::DEF_JOINT_COUNT,
	parameter int STEP_BITS   = cjss_pkg::DEF_STEP_BITS,
	localparam int DATA_W     = ((cjss_pkg::MAX_JOINTS * STEP_BITS + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata,
	input logic [0:0]        m_axis_tuser
);
	import cjss_pkg::*;

	localparam int USED_W = JOINT_COUNT * STEP_BITS;

	// stalled result beat holds
	`CHK_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

	// input backpressure only behind a blocked result
	`CHK_IMPLIES(a_stall_cause, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with output free")

	// a result leaves only when taken
	`CHK_IMPLIES(a_no_drop, clk, arst_n, $fell(m_axis_tvalid), $past(m_axis_tready), "result beat dropped")

	if (USED_W < DATA_W) begin : g_unused
		// unused joints and padding read as zero
		`CHK_IMPLIES(a_unused_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[DATA_W-1:USED_W] == '0, "unused result bits not zero")
	end

endmodule

bind closest_joint_solution_select_unit cjss_checker #(
	.JOINT_COUNT(JOINT_COUNT),
	.STEP_BITS  (STEP_BITS)
) u_cjss_checker (.*);

FILE: bench/testbench.sv
// Testbench for the closest joint solution selector: directed table and random beats vs a predictor.
`timescale 1ns / 1ps

module testbench;
	import cjss_pkg::*;

	localparam int JOINTS      = DEF_JOINT_COUNT;
	localparam int STEP_BITS   = DEF_STEP_BITS;
	localparam int DATA_W      = ((MAX_JOINTS * STEP_BITS + 7) / 8) * 8;
	localparam int COST_W      = 28;
	localparam int STEP_MAX    = 8388607;
	localparam int STEP_MIN    = -8388608;
	localparam int TOTAL_BEATS = 1870;
	localparam int CALM_BEATS  = 150;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic [MAX_JOINTS-1:0][STEP_BITS-1:0] pose_t;

	typedef struct {
		logic  op;
		pose_t pose;
		logic  last;
		bit    typed;
		logic  exp_from;
	} beat_t;

	typedef struct {
		pose_t pose;
		logic  from_cand;
	} sel_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;  // joint0 .. joint5, STEP_BITS each
	logic [0:0]        s_axis_tuser;  // operation
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [DATA_W-1:0] m_axis_tdata;  // best_joint0 .. best_joint5, STEP_BITS each
	logic [0:0]        m_axis_tuser;  // from_candidate

	// expectation typed into the table for the beat on the bus
	bit   drv_typed;
	logic drv_exp_from;

	beat_t       beats[$];
	sel_result_t chosen_q[$];
	int          errors = 0;
	int          sent_idx = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;

	// predictor state
	pose_t             home_pose;
	pose_t             best_pose;
	logic [COST_W-1:0] best_cost;
	bit                best_valid;

	closest_joint_solution_select_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, chosen_q.size());
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic pose_t uniform_pose(int v);
		pose_t p;
		for (int i = 0; i < MAX_JOINTS; i++)
			p[i] = STEP_BITS'(v);
		return p;
	endfunction

	function automatic pose_t pose_of(int a, int b, int c, int d, int e, int f);
		pose_t p;
		p[0] = STEP_BITS'(a);
		p[1] = STEP_BITS'(b);
		p[2] = STEP_BITS'(c);
		p[3] = STEP_BITS'(d);
		p[4] = STEP_BITS'(e);
		p[5] = STEP_BITS'(f);
		return p;
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		for (int i = 0; i < MAX_JOINTS; i++)
			p[i] = STEP_BITS'($urandom());
		return p;
	endfunction

	function automatic pose_t shift_pose(pose_t base, input int delta [MAX_JOINTS]);
		pose_t p;
		for (int i = 0; i < MAX_JOINTS; i++)
			p[i] = STEP_BITS'(int'($signed(base[i])) + delta[i]);
		return p;
	endfunction

	function automatic void add_beat(logic op, pose_t pose, logic last, bit typed = 1'b0,
			logic exp_from = 1'b0);
		beat_t b;
		b.op       = op;
		b.pose     = pose;
		b.last     = last;
		b.typed    = typed;
		b.exp_from = exp_from;
		beats      = {beats, b};
	endfunction

	// Nearest-by-L1 selection, one beat at a time.
	task automatic score_and_select(input logic op, input pose_t data, input logic last,
			output bit emits, output sel_result_t res);
		pose_t                    joint;
		logic [COST_W-1:0]        cost;
		logic signed [STEP_BITS:0] diff;
		bit                       take;
		joint = '0;
		for (int i = 0; i < JOINTS; i++)
			joint[i] = data[i];
		if (op == OP_CURRENT) begin
			home_pose  = joint;
			best_valid = 1'b0;
			best_cost  = '1;
		end else begin
			cost = '0;
			for (int i = 0; i < JOINTS; i++) begin
				diff = $signed(joint[i]) - $signed(home_pose[i]);
				cost = cost + COST_W'(diff[STEP_BITS] ? -diff : diff);
			end
			if (!best_valid)
				take = 1'b1;
			else if (cost < best_cost)
				take = 1'b1;
			else if (cost == best_cost)
				take = $signed(joint[TIE_JOINT]) > $signed(best_pose[TIE_JOINT]);
			else
				take = 1'b0;
			if (take) begin
				best_pose  = joint;
				best_cost  = cost;
				best_valid = 1'b1;
			end
		end
		emits = last;
		res.pose      = best_valid ? best_pose : home_pose;
		res.from_cand = best_valid;
		if (last) begin
			best_valid = 1'b0;
			best_cost  = '1;
		end
	endtask

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		bit          emits;
		sel_result_t res;
		sel_result_t want;
		pose_t       got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				score_and_select(s_axis_tuser[0], s_axis_tdata, s_axis_tlast, emits, res);
				if (emits) begin
					if (drv_typed) begin
						res.pose      = s_axis_tdata;
						res.from_cand = drv_exp_from;
					end
					chosen_q = {chosen_q, res};
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (chosen_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result expected none actual %h / %b",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					want = chosen_q.pop_front();
					compare_field("best_joint0", $signed(want.pose[0]), $signed(got[0]));
					compare_field("best_joint1", $signed(want.pose[1]), $signed(got[1]));
					compare_field("best_joint2", $signed(want.pose[2]), $signed(got[2]));
					compare_field("best_joint3", $signed(want.pose[3]), $signed(got[3]));
					compare_field("best_joint4", $signed(want.pose[4]), $signed(got[4]));
					compare_field("best_joint5", $signed(want.pose[5]), $signed(got[5]));
					compare_field("from_candidate", want.from_cand, m_axis_tuser[0]);
				end
			end
		end
	end

	task automatic build_directed();
		// candidate before any current: scored against the zero reference
		add_beat(OP_CANDIDATE, uniform_pose(0), 1'b1, 1'b1, 1'b1);
		// last on a current beat
		add_beat(OP_CURRENT, uniform_pose(STEP_MAX), 1'b1, 1'b1, 1'b0);
		add_beat(OP_CURRENT, uniform_pose(STEP_MIN), 1'b0);
		add_beat(OP_CANDIDATE, uniform_pose(STEP_MAX), 1'b0);
		add_beat(OP_CANDIDATE, uniform_pose(STEP_MIN), 1'b1, 1'b1, 1'b1);
		// fresh selection after an emission, same reference
		add_beat(OP_CANDIDATE, uniform_pose(STEP_MAX), 1'b1, 1'b1, 1'b1);
		// equal cost: greater joint 2 wins, smaller or equal loses
		add_beat(OP_CURRENT, uniform_pose(0), 1'b0);
		add_beat(OP_CANDIDATE, pose_of(1, 0, 0, 0, 0, 0), 1'b0);
		add_beat(OP_CANDIDATE, pose_of(0, 0, 1, 0, 0, 0), 1'b0);
		add_beat(OP_CANDIDATE, pose_of(0, 0, 0, 0, 0, -1), 1'b0);
		add_beat(OP_CANDIDATE, pose_of(0, -1, 0, 0, 0, 0), 1'b1);
		add_beat(OP_CANDIDATE, pose_of(0, 0, -5, 0, 0, 0), 1'b0);
		add_beat(OP_CANDIDATE, pose_of(5, 0, 0, 0, 0, 0), 1'b0);
		add_beat(OP_CANDIDATE, pose_of(0, 0, -5, 0, 0, 0), 1'b1);
		// current after candidates restarts the selection
		add_beat(OP_CANDIDATE, uniform_pose(3), 1'b0);
		add_beat(OP_CURRENT, pose_of(100, -100, 200, -200, 300, -300), 1'b1, 1'b1, 1'b0);
		add_beat(OP_CANDIDATE, pose_of(100, -100, 200, -200, 300, -300), 1'b0);
		add_beat(OP_CANDIDATE, pose_of(101, -100, 200, -200, 300, -300), 1'b0);
		add_beat(OP_CURRENT, pose_of(-7, 7, -7, 7, -7, 7), 1'b0);
		add_beat(OP_CANDIDATE, pose_of(STEP_MAX, STEP_MIN, STEP_MAX, STEP_MIN, STEP_MAX,
			STEP_MIN), 1'b1);
		add_beat(OP_CURRENT, pose_of(STEP_MIN, STEP_MAX, STEP_MIN, STEP_MAX, STEP_MIN,
			STEP_MAX), 1'b0);
		add_beat(OP_CANDIDATE, pose_of(STEP_MAX, STEP_MIN, STEP_MAX, STEP_MIN, STEP_MAX,
			STEP_MIN), 1'b0);
		add_beat(OP_CANDIDATE, uniform_pose(-1), 1'b1);
	endtask

	task automatic build_random();
		pose_t ref_p;
		pose_t cand;
		int    off [MAX_JOINTS];
		int    n;
		int    sw;
		int    tmp;
		bit    with_last;
		bit    end_on_current;
		while (beats.size() < TOTAL_BEATS) begin
			if ($urandom_range(0, 9) == 0) begin
				add_beat(logic'($urandom_range(0, 1)), random_pose(),
					logic'($urandom_range(0, 1)));
				continue;
			end
			case ($urandom_range(0, 3))
				0: ref_p = random_pose();
				3: begin
					for (int i = 0; i < MAX_JOINTS; i++)
						ref_p[i] = $urandom_range(0, 1) ?
							STEP_BITS'(STEP_MAX - int'($urandom_range(0, 3))) :
							STEP_BITS'(STEP_MIN + int'($urandom_range(0, 3)));
				end
				default: begin
					for (int i = 0; i < MAX_JOINTS; i++)
						ref_p[i] = STEP_BITS'(int'($urandom_range(0, 2000)) - 1000);
				end
			endcase
			if ($urandom_range(0, 7) != 0)
				add_beat(OP_CURRENT, ref_p, 1'b0);
			n              = $urandom_range(0, 8);
			with_last      = $urandom_range(0, 9) != 0;
			end_on_current = (n == 0) || ($urandom_range(0, 5) == 0);
			cand           = ref_p;
			for (int i = 0; i < MAX_JOINTS; i++)
				off[i] = 0;
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(0, 5))
					0: cand = random_pose();
					1: begin
						for (int i = 0; i < MAX_JOINTS; i++)
							off[i] = int'($urandom_range(0, 40)) - 20;
						cand = shift_pose(ref_p, off);
					end
					2: begin
						// same cost, joint 2 mirrored
						off[TIE_JOINT] = -off[TIE_JOINT];
						cand = shift_pose(ref_p, off);
					end
					3: begin
						sw             = $urandom_range(0, MAX_JOINTS - 1);
						tmp            = off[TIE_JOINT];
						off[TIE_JOINT] = off[sw];
						off[sw]        = tmp;
						cand           = shift_pose(ref_p, off);
					end
					4: ; // repeat the previous candidate
					default: begin
						for (int i = 0; i < MAX_JOINTS; i++)
							off[i] = int'($urandom());
						cand = shift_pose(ref_p, off);
					end
				endcase
				add_beat(OP_CANDIDATE, cand, with_last && !end_on_current && (k == n - 1));
			end
			if (with_last && end_on_current)
				add_beat(OP_CURRENT, $urandom_range(0, 1) ? ref_p : random_pose(), 1'b1);
		end
	endtask

	initial begin : receiver
		int  n;
		int  window;
		bit  rx_quiet;
		bit  held;
		m_axis_tready = 1'b0;
		window        = 0;
		rx_quiet      = 1'b0;
		held          = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			window++;
			if (window % 64 == 0)
				rx_quiet = $urandom_range(0, 2) == 0;
			if (!held && sent_idx >= HOLD_AT) begin
				// long hold-off: input side must back up
				held          = 1'b1;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 1'b0;
				n             = $urandom_range(1, 14);
				repeat (n - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	initial begin : sender
		int gap;
		bit tx_quiet;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		drv_typed     = 1'b0;
		drv_exp_from  = 1'b0;
		tx_quiet      = 1'b0;
		home_pose     = '0;
		best_pose     = '0;
		best_cost     = '1;
		best_valid    = 1'b0;
		build_directed();
		build_random();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int idx = 0; idx < beats.size(); idx++) begin
			calm = idx >= beats.size() - CALM_BEATS;
			if (idx % 50 == 0)
				tx_quiet = $urandom_range(0, 2) == 0;
			if (!calm && !tx_quiet && $urandom_range(0, 6) == 0) begin
				s_axis_tvalid = 1'b0;
				gap           = $urandom_range(1, 14);
				repeat (gap) @(negedge clk);
			end
			s_axis_tdata  = beats[idx].pose;
			s_axis_tuser  = beats[idx].op;
			s_axis_tlast  = beats[idx].last;
			drv_typed     = beats[idx].typed;
			drv_exp_from  = beats[idx].exp_from;
			s_axis_tvalid = 1'b1;
			do @(posedge clk); while (!s_axis_tready);
			@(negedge clk);
			sent_idx = idx + 1;
		end
		s_axis_tvalid = 1'b0;
		while (chosen_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && chosen_q.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
